/* rtl/tsad_pkg.sv */
// Shared types, constants and the arctangent table for the tilt angle difference block.
// Depends on nothing; every RTL file refers to it by scoped names.

package tsad_pkg;

   localparam int ACCEL_W             = 16;
   localparam int INPUT_SCALE_SHIFT   = 8;
   localparam int PROD_W              = 2 * ACCEL_W - 1;
   localparam int SQRT_W              = 2 * ACCEL_W + 2 * INPUT_SCALE_SHIFT;
   localparam int SQRT_STEPS          = SQRT_W / 2;
   localparam int ROOT_W              = SQRT_W / 2;
   localparam int VEC_W               = 27;
   localparam int ANGLE_INT_BITS      = 9;
   localparam int TABLE_FRACTION_BITS = 24;
   localparam int TABLE_LEN           = 32;
   localparam int MAX_DEGREES         = 180;
   localparam int OUT_W               = 8;

   // atan(2^-i) in degrees, 24 fraction bits
   localparam logic [31:0] ATAN_DEG_Q24 [TABLE_LEN] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
      32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
      32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
      32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
      32'd917,       32'd458,       32'd229,       32'd115,       32'd57,
      32'd29,        32'd14,        32'd7,         32'd4,         32'd2,
      32'd1,         32'd0
   };

   typedef struct packed {
      logic [SQRT_W-1:0]         rem;
      logic [SQRT_W-1:0]         root;
      logic signed [ACCEL_W-1:0] accel_x;
      logic                      zero;
   } sqrt_lane_type;

   typedef struct packed {
      logic                    valid;
      sqrt_lane_type [1:0]     lane;
   } sqrt_beat_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] vec_x;
      logic signed [VEC_W-1:0] vec_y;
      logic                    zero;
   } vec_type;

   // Round the table entry half up to the requested number of fraction bits.
   function automatic logic [31:0] angle_step(input int step, input int frac);
      logic [63:0] t;
      int          sh;
      if (step >= TABLE_LEN) begin
         return '0;
      end
      t  = {32'd0, ATAN_DEG_Q24[step]};
      sh = TABLE_FRACTION_BITS - frac;
      if (sh == 0) begin
         return t[31:0];
      end
      t = (t + (64'd1 << (sh - 1))) >> sh;
      return t[31:0];
   endfunction

endpackage

/* rtl/tsad_sqrt_cell.sv */
// One bit step of the pipelined integer square root, both sensor lanes.
// Depends on tsad_pkg for the lane and beat types.

module tsad_sqrt_cell #(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  tsad_pkg::sqrt_beat_type in_beat,
   output tsad_pkg::sqrt_beat_type out_beat
);

   localparam int SW = tsad_pkg::SQRT_W;
   localparam logic [SW:0] BIT = {{SW{1'b0}}, 1'b1} << (SW - 2 - 2 * STEP);

   tsad_pkg::sqrt_lane_type [1:0] lane_in;
   tsad_pkg::sqrt_lane_type [1:0] lane_ff;
   logic                          valid_ff;

   always_comb begin
      logic [SW:0] trial;
      for (int l = 0; l < 2; l++) begin
         lane_in[l] = in_beat.lane[l];
         trial      = {1'b0, in_beat.lane[l].root} + BIT;
         if ({1'b0, in_beat.lane[l].rem} >= trial) begin
            lane_in[l].rem  = in_beat.lane[l].rem - trial[SW-1:0];
            lane_in[l].root = (in_beat.lane[l].root >> 1) + BIT[SW-1:0];
         end else begin
            lane_in[l].root = in_beat.lane[l].root >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_beat.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign out_beat.valid = valid_ff;
   assign out_beat.lane  = lane_ff;

endmodule

/* rtl/tsad_cordic_cell.sv */
// One vectoring CORDIC rotation with its angle accumulator, both sensor lanes.
// Depends on tsad_pkg for the vector type and the arctangent table.

module tsad_cordic_cell #(
   parameter int STEP = 0,
   parameter int ZW   = 25,
   parameter int FRAC = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  tsad_pkg::vec_type [1:0]     in_vec,
   input  logic signed [ZW-1:0]        in_angle [2],
   output logic                        out_valid,
   output tsad_pkg::vec_type [1:0]     out_vec,
   output logic signed [ZW-1:0]        out_angle [2]
);

   localparam logic signed [ZW-1:0] ANGLE = ZW'(tsad_pkg::angle_step(STEP, FRAC));

   tsad_pkg::vec_type [1:0]  vec_in;
   tsad_pkg::vec_type [1:0]  vec_ff;
   logic signed [ZW-1:0]     angle_in [2];
   logic signed [ZW-1:0]     angle_ff [2];
   logic                     valid_ff;

   always_comb begin
      logic signed [tsad_pkg::VEC_W-1:0] x;
      logic signed [tsad_pkg::VEC_W-1:0] y;
      logic signed [tsad_pkg::VEC_W-1:0] xs;
      logic signed [tsad_pkg::VEC_W-1:0] ys;
      for (int l = 0; l < 2; l++) begin
         x  = in_vec[l].vec_x;
         y  = in_vec[l].vec_y;
         xs = x >>> STEP;
         ys = y >>> STEP;
         vec_in[l].zero = in_vec[l].zero;
         // rotate toward the x axis
         if (y[tsad_pkg::VEC_W-1]) begin
            vec_in[l].vec_x = x - ys;
            vec_in[l].vec_y = y + xs;
            angle_in[l]     = in_angle[l] - ANGLE;
         end else begin
            vec_in[l].vec_x = x + ys;
            vec_in[l].vec_y = y - xs;
            angle_in[l]     = in_angle[l] + ANGLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff   <= vec_in;
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_angle = angle_ff;

endmodule

/* rtl/two_sensor_tilt_angle_difference.sv */
// Top level: pitch of two accelerometer triples and their absolute difference in degrees.
// Depends on tsad_pkg, tsad_sqrt_cell and tsad_cordic_cell.
//
//   channel   direction  ports              beat content
//   req       in         req_tvalid/tready  six 16-bit signed axes, fixed then mobile
//   rsp       out        rsp_tvalid/tready  8-bit unsigned pitch difference, 0..180
//
// One beat per clock enters and one leaves, sustained while rsp_tready stays high; each
// square-root bit and each CORDIC rotation is a cell of its own. From req acceptance to
// rsp_tvalid a beat passes one squaring stage, 24 root cells, CORDIC_STEPS rotation
// cells, a difference stage and the output register.
// Reset clears only the valid bits: squaring, cell, difference, output and skid registers.
// A stalled rsp parks the next result in a skid register; req_tready drops only while
// the skid register is full, and then the whole chain holds.

module two_sensor_tilt_angle_difference #(
   parameter int CORDIC_STEPS        = 20,
   parameter int ANGLE_FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // fixed_accel_x, fixed_accel_y, fixed_accel_z,
   // mobile_accel_x, mobile_accel_y, mobile_accel_z (16 bits each, signed)
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // seat_angle_degrees (8 bits, unsigned)
   output logic [7:0]  rsp_tdata
);

   localparam int AW    = tsad_pkg::ACCEL_W;
   localparam int PW    = tsad_pkg::PROD_W;
   localparam int SHIFT = tsad_pkg::INPUT_SCALE_SHIFT;
   localparam int ZW    = ANGLE_FRACTION_BITS + tsad_pkg::ANGLE_INT_BITS;
   localparam int DW    = ZW + 1;
   localparam int DEG_W = DW - ANGLE_FRACTION_BITS;
   localparam int OW    = tsad_pkg::OUT_W;

   logic advance;

   // ---------------------------------------------------------------- input squaring
   logic signed [AW-1:0] in_x [2];
   logic signed [AW-1:0] in_y [2];
   logic signed [AW-1:0] in_z [2];

   assign in_x[0] = req_tdata[15:0];
   assign in_y[0] = req_tdata[31:16];
   assign in_z[0] = req_tdata[47:32];
   assign in_x[1] = req_tdata[63:48];
   assign in_y[1] = req_tdata[79:64];
   assign in_z[1] = req_tdata[95:80];

   logic signed [2*AW-1:0] prod_y [2];
   logic signed [2*AW-1:0] prod_z [2];
   logic [PW-1:0]          sq_y_ff [2];
   logic [PW-1:0]          sq_z_ff [2];
   logic signed [AW-1:0]   px_ff [2];
   logic                   pzero_ff [2];
   logic                   prod_valid_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         prod_y[l] = in_y[l] * in_y[l];
         prod_z[l] = in_z[l] * in_z[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < 2; l++) begin
            sq_y_ff[l]  <= prod_y[l][PW-1:0];
            sq_z_ff[l]  <= prod_z[l][PW-1:0];
            px_ff[l]    <= in_x[l];
            // an all-zero triple has pitch exactly zero
            pzero_ff[l] <= (in_x[l] == '0) && (in_y[l] == '0) && (in_z[l] == '0);
         end
      end
   end

   // ---------------------------------------------------------------- square root chain
   tsad_pkg::sqrt_beat_type sq_beat [tsad_pkg::SQRT_STEPS+1];

   always_comb begin
      logic [PW:0] sum;
      sq_beat[0].valid = prod_valid_ff;
      for (int l = 0; l < 2; l++) begin
         sum = {1'b0, sq_y_ff[l]} + {1'b0, sq_z_ff[l]};
         sq_beat[0].lane[l].rem     = {sum, {(2 * SHIFT){1'b0}}};
         sq_beat[0].lane[l].root    = '0;
         sq_beat[0].lane[l].accel_x = px_ff[l];
         sq_beat[0].lane[l].zero    = pzero_ff[l];
      end
   end

   for (genvar s = 0; s < tsad_pkg::SQRT_STEPS; s++) begin : g_sqrt
      tsad_sqrt_cell #(
         .STEP (s)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .in_beat  (sq_beat[s]),
         .out_beat (sq_beat[s+1])
      );
   end

   // ---------------------------------------------------------------- CORDIC chain
   logic                    cd_valid [CORDIC_STEPS+1];
   tsad_pkg::vec_type [1:0] cd_vec   [CORDIC_STEPS+1];
   logic signed [ZW-1:0]    cd_angle [CORDIC_STEPS+1][2];

   // start at X = root, Y = x scaled up, angle zero
   always_comb begin
      cd_valid[0] = sq_beat[tsad_pkg::SQRT_STEPS].valid;
      for (int l = 0; l < 2; l++) begin
         cd_vec[0][l].vec_x = {{(tsad_pkg::VEC_W - tsad_pkg::ROOT_W){1'b0}},
                               sq_beat[tsad_pkg::SQRT_STEPS].lane[l].root[tsad_pkg::ROOT_W-1:0]};
         cd_vec[0][l].vec_y = {{(tsad_pkg::VEC_W - AW - SHIFT)
                                {sq_beat[tsad_pkg::SQRT_STEPS].lane[l].accel_x[AW-1]}},
                               sq_beat[tsad_pkg::SQRT_STEPS].lane[l].accel_x,
                               {SHIFT{1'b0}}};
         cd_vec[0][l].zero  = sq_beat[tsad_pkg::SQRT_STEPS].lane[l].zero;
         cd_angle[0][l]     = '0;
      end
   end

   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
      tsad_cordic_cell #(
         .STEP (s),
         .ZW   (ZW),
         .FRAC (ANGLE_FRACTION_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cd_valid[s]),
         .in_vec    (cd_vec[s]),
         .in_angle  (cd_angle[s]),
         .out_valid (cd_valid[s+1]),
         .out_vec   (cd_vec[s+1]),
         .out_angle (cd_angle[s+1])
      );
   end

   // ---------------------------------------------------------------- difference stage
   logic signed [ZW-1:0] pitch [2];
   logic signed [DW-1:0] diff_in;
   logic signed [DW-1:0] diff_ff;
   logic                 diff_valid_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         pitch[l] = cd_vec[CORDIC_STEPS][l].zero ? '0 : cd_angle[CORDIC_STEPS][l];
      end
      diff_in = {pitch[0][ZW-1], pitch[0]} - {pitch[1][ZW-1], pitch[1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
      end else if (advance) begin
         diff_valid_ff <= cd_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff <= diff_in;
      end
   end

   // magnitude, drop the fraction, saturate at the top of the range
   logic [DW-1:0]    mag;
   logic [DEG_W-1:0] deg;
   logic [OW-1:0]    result;

   always_comb begin
      mag = diff_ff[DW-1] ? DW'(-diff_ff) : DW'(diff_ff);
      deg = mag[DW-1:ANGLE_FRACTION_BITS];
      if (deg > DEG_W'(tsad_pkg::MAX_DEGREES)) begin
         result = OW'(tsad_pkg::MAX_DEGREES);
      end else begin
         result = deg[OW-1:0];
      end
   end

   // ---------------------------------------------------------------- output and skid
   logic          rsp_tvalid_ff;
   logic [OW-1:0] rsp_data_ff;
   logic          skid_valid_ff;
   logic [OW-1:0] skid_data_ff;
   logic          deliver;

   assign advance = !skid_valid_ff;
   assign deliver = advance && diff_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_tvalid_ff && !rsp_tready) begin
         // hold the waiting beat, park the next one
         if (deliver) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_tvalid_ff <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= deliver;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tvalid_ff && !rsp_tready) begin
         if (deliver) begin
            skid_data_ff <= result;
         end
      end else if (skid_valid_ff) begin
         rsp_data_ff <= skid_data_ff;
      end else if (deliver) begin
         rsp_data_ff <= result;
      end
   end

   assign req_tready = advance;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- assertions
   a_skid_behind_output : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_tvalid_ff)
      else $error("skid register full while output register empty");

   a_skid_fill_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_tvalid_ff && !rsp_tready))
      else $error("skid register filled without an output stall");

   a_result_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata <= OW'(tsad_pkg::MAX_DEGREES)))
      else $error("result beyond the saturation limit");

endmodule

/* test/tb_top.sv */
// Testbench for two_sensor_tilt_angle_difference: the stream ports are driven with
// accelerometer pairs and every returned angle is checked against a predictor in the bench.
// Depends on the RTL top level only.

class tilt_diff_board;

   localparam int CORDIC_STEPS        = 20;
   localparam int ANGLE_FRACTION_BITS = 16;
   localparam int TABLE_FRACTION_BITS = 24;
   localparam int SCALE_SHIFT         = 8;
   localparam int MAX_DEGREES         = 180;
   localparam int REPORT_LIMIT        = 10;

   longint     atan_q24 [32];
   logic [7:0] expected_angles [$];
   int         mismatches;

   function new();
      // atan(2^-i) in degrees, 24 fraction bits
      atan_q24 = '{
         754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
         15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
         58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
         7, 4, 2, 1, 0
      };
      mismatches = 0;
   endfunction

   function longint atan_step(int i);
      int sh;
      sh = TABLE_FRACTION_BITS - ANGLE_FRACTION_BITS;
      if (i >= 32) begin
         return 0;
      end
      if (sh == 0) begin
         return atan_q24[i];
      end
      return (atan_q24[i] + (longint'(1) << (sh - 1))) >>> sh;
   endfunction

   function longint unsigned floor_root(longint unsigned v);
      longint unsigned res;
      longint unsigned probe;
      res   = 0;
      probe = longint'(1) << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v   = v - (res + probe);
            res = (res >> 1) + probe;
         end else begin
            res = res >> 1;
         end
         probe >>= 2;
      end
      return res;
   endfunction

   // Pitch in degrees with ANGLE_FRACTION_BITS fraction bits, by vectoring CORDIC.
   function longint tilt_of(shortint ax, shortint ay, shortint az);
      longint unsigned sum;
      longint          vx;
      longint          vy;
      longint          va;
      longint          sx;
      longint          sy;
      sum = longint'(ay) * longint'(ay) + longint'(az) * longint'(az);
      vx  = longint'(floor_root(sum << (2 * SCALE_SHIFT)));
      vy  = longint'(ax) * (longint'(1) << SCALE_SHIFT);
      va  = 0;
      if (vx == 0 && vy == 0) begin
         return 0;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         sx = vx >>> i;
         sy = vy >>> i;
         if (vy < 0) begin
            vx = vx - sy;
            vy = vy + sx;
            va = va - atan_step(i);
         end else begin
            vx = vx + sy;
            vy = vy - sx;
            va = va + atan_step(i);
         end
      end
      return va;
   endfunction

   function logic [7:0] predict_angle(logic [95:0] pair);
      longint d;
      longint deg;
      d = tilt_of(pair[15:0], pair[31:16], pair[47:32])
        - tilt_of(pair[63:48], pair[79:64], pair[95:80]);
      if (d < 0) begin
         d = -d;
      end
      deg = d >>> ANGLE_FRACTION_BITS;
      if (deg > MAX_DEGREES) begin
         deg = MAX_DEGREES;
      end
      return deg[7:0];
   endfunction

   function void note_pair(logic [95:0] pair);
      expected_angles.push_back(predict_angle(pair));
   endfunction

   function void check_angle(logic [7:0] got);
      logic [7:0] want;
      if (expected_angles.size() == 0) begin
         if (mismatches < REPORT_LIMIT) begin
            $display("unexpected angle beat: got %0d with nothing pending", got);
         end
         mismatches++;
         return;
      end
      want = expected_angles.pop_front();
      if (got !== want) begin
         if (mismatches < REPORT_LIMIT) begin
            $display("angle mismatch: expected %0d, got %0d", want, got);
         end
         mismatches++;
      end
   endfunction

   function int waiting();
      return expected_angles.size();
   endfunction

endclass

module tb_top;

   localparam int RANDOM_PAIRS = 1750;
   localparam int LONG_HOLD    = 300;   // rsp back-pressure hold, fills the pipe
   localparam int HOLD_AT      = 500;   // random pair index that kicks off the long hold
   localparam int DRAIN_CYCLES = 80;    // watch for stray beats a bit longer than the pipe latency
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   bit             long_hold_go = 1'b0;
   int             burst_left   = 0;
   int             cycles       = 0;
   tilt_diff_board board        = new();

   always #5 clock = ~clock;

   two_sensor_tilt_angle_difference i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Watch both channels at the rising edge: every accepted req beat gets a prediction,
   // every accepted rsp beat is checked against the oldest one.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_pair(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_angle(rsp_tdata);
         end
      end
   end

   // Give up if the run hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Receiver pacing: switch between a handful of stall patterns, each for a random
   // stretch. Once the stimulus asks for it, hold rsp_tready low through one long hold
   // so results back up into the skid register and req_tready drops.
   initial begin : rsp_pacer
      int  mode;
      int  span;
      int  period;
      bit  held;
      held = 1'b0;
      forever begin
         mode   = $urandom_range(0, 4);
         span   = $urandom_range(40, 300);
         period = $urandom_range(2, 7);
         for (int phase = 0; phase < span; phase++) begin
            @(negedge clock);
            if (long_hold_go && !held) begin
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD - 1) @(negedge clock);
               held = 1'b1;
            end else begin
               case (mode)
                  0: begin
                     rsp_tready <= 1'b1;
                  end
                  1: begin
                     rsp_tready <= 1'($urandom_range(0, 1));
                  end
                  2: begin
                     rsp_tready <= ($urandom_range(0, 9) != 0);
                  end
                  3: begin
                     rsp_tready <= ((phase % period) != (period - 1));
                  end
                  default: begin
                     rsp_tready <= ($urandom_range(0, 4) == 0);
                  end
               endcase
            end
         end
      end
   end

   // Drop valid for a pause set by n.
   task automatic pause_req(int n);
      if (n > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Offer one beat and hold it until the block takes it. Bursts of random length
   // run back to back; a random gap (often none) opens each new burst.
   task automatic send_pair(logic [95:0] pair);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 30);
         pause_req(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= pair;
      do @(posedge clock); while (!req_tready);
   endtask

   // Pack fixed x, y, z then mobile x, y, z, lowest bits first.
   task automatic send_axes(shortint fx, shortint fy, shortint fz,
                            shortint mx, shortint my, shortint mz);
      send_pair({mz, my, mx, fz, fy, fx});
   endtask

   // Pick one axis reading: half the time full range, else extremes, zero, small and mid magnitudes.
   function automatic shortint pick_axis();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         4: begin
            case ($urandom_range(0, 4))
               0: return -16'sd32768;
               1: return 16'sd32767;
               2: return -16'sd1;
               3: return 16'sd1;
               default: return 16'sd0;
            endcase
         end
         5, 6: begin
            return shortint'($urandom_range(0, 511)) - 16'sd256;
         end
         7: begin
            return shortint'($urandom_range(0, 8191)) - 16'sd4096;
         end
         8: begin
            return 16'sd0;
         end
         default: begin
            return shortint'($urandom());
         end
      endcase
   endfunction

   task automatic send_random_pair();
      shortint ax [6];
      foreach (ax[k]) ax[k] = pick_axis();
      // Now and then make one triple all zero, or both triples equal.
      case ($urandom_range(0, 19))
         0: begin
            ax[0] = 0;
            ax[1] = 0;
            ax[2] = 0;
         end
         1: begin
            ax[3] = 0;
            ax[4] = 0;
            ax[5] = 0;
         end
         2: begin
            ax[3] = ax[0];
            ax[4] = ax[1];
            ax[5] = ax[2];
         end
         default: begin
         end
      endcase
      send_axes(ax[0], ax[1], ax[2], ax[3], ax[4], ax[5]);
   endtask

   initial begin : stimulus
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // Directed pairs: zero triples, axis extremes, both signs and the saturation corner.
      send_axes(0, 0, 0, 0, 0, 0);
      send_axes(32767, 0, 0, -32768, 0, 0);
      send_axes(-32768, 0, 0, 32767, 0, 0);
      send_axes(-32768, 0, 0, 0, 0, 0);
      send_axes(0, 0, 0, 32767, 0, 0);
      send_axes(1, 0, 0, -1, 0, 0);
      send_axes(0, 0, 1, 1, 0, 0);
      send_axes(0, -32768, -32768, 32767, 32767, 32767);
      send_axes(-32768, -32768, -32768, 32767, 32767, 32767);
      send_axes(-32768, -32768, -32768, -32768, -32768, -32768);
      send_axes(100, 0, 100, -100, 100, 0);
      send_axes(0, 32767, 0, 0, 0, -32768);
      send_axes(-1, -1, -1, 1, 1, 1);
      send_axes(32767, 1, 0, -32768, 0, -1);
      send_axes(12345, -222, 3333, 12345, -222, 3333);
      send_axes(-32768, 0, 1, 32767, 1, 0);

      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         if (n == HOLD_AT) begin
            long_hold_go = 1'b1;
         end
         send_random_pair();
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // Let the pipe drain, then watch for stray beats.
      while (board.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.waiting() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/tsad_pkg.sv
rtl/tsad_sqrt_cell.sv
rtl/tsad_cordic_cell.sv
rtl/two_sensor_tilt_angle_difference.sv
test/tb_top.sv
